/* hw/rtl/cma_pkg.sv */
// Package for the circular mean accumulator: item types, fixed-point constants,
// CORDIC arctangent table. No dependencies.
package cma_pkg;

    localparam int COUNT_BITS_DEF   = 20;
    localparam int TRIG_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int VEC_FRAC  = 30;
    localparam int TABLE_LEN = 24;
    localparam int ZW        = 36;   // CORDIC angle width, degrees * 2^24
    localparam int VW        = 34;   // CORDIC vector width, Q30 plus headroom

    localparam logic signed [VW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [ZW-1:0] DEG90  = 36'sd1509949440;
    localparam logic signed [ZW-1:0] DEG180 = 36'sd3019898880;
    localparam logic signed [ZW-1:0] DEG360 = 36'sd6039797760;
    localparam logic [24:0] FULL_TURN_Q16 = 25'd23592960;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic signed [31:0] angle_deg;
    } in_item_t;

    typedef struct packed {
        logic [19:0] sample_count;
        logic        mean_valid;
        logic [24:0] mean_angle;
        logic        count_full;
    } out_item_t;

    function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        begin
            unique case (i)
                5'd0: r = 36'sd754974720;   5'd1: r = 36'sd445687602;
                5'd2: r = 36'sd235489088;   5'd3: r = 36'sd119537938;
                5'd4: r = 36'sd60000934;    5'd5: r = 36'sd30029717;
                5'd6: r = 36'sd15018523;    5'd7: r = 36'sd7509720;
                5'd8: r = 36'sd3754917;     5'd9: r = 36'sd1877466;
                5'd10: r = 36'sd938734;     5'd11: r = 36'sd469367;
                5'd12: r = 36'sd234684;     5'd13: r = 36'sd117342;
                5'd14: r = 36'sd58671;      5'd15: r = 36'sd29335;
                5'd16: r = 36'sd14668;      5'd17: r = 36'sd7334;
                5'd18: r = 36'sd3667;       5'd19: r = 36'sd1833;
                5'd20: r = 36'sd917;        5'd21: r = 36'sd458;
                5'd22: r = 36'sd229;        5'd23: r = 36'sd115;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

/* hw/rtl/circular_mean_accumulator.sv */
// Top level of the circular mean accumulator: front queue plus back-end
// CORDIC engine. Depends on cma_pkg, cma_front, cma_back.
//
// Usage: items enter on s_valid/s_ready/s_item (cmd, angle_deg Q16.16) and
// one result per item leaves on m_valid/m_ready/m_item (sample_count,
// mean_valid, mean_angle Q9.16, count_full). cmd CLEAR zeroes the count and
// sums; an add with a saturated count is ignored and flagged count_full.
// A two-entry queue takes items while the back end works.
// An add item passes the queue, the modulo reduction, the CORDIC rotation
// steps, the normalize shifts, the CORDIC vectoring steps and the output
// register; the vectoring is skipped when the sums cancel. A saturated add
// skips the modulo reduction and rotation, and a clear goes straight to output.
// One shared CORDIC datapath sets the rate: the back end takes the next item
// the cycle after its result is accepted.
// Reset (aresetn low, synchronous) clears count, sums, queue and output.
// A stalled receiver holds the result; the back end waits until it is taken
// and the queue then fills and deasserts s_ready.
module circular_mean_accumulator
    import cma_pkg::*;
#(
    parameter int COUNT_BITS   = COUNT_BITS_DEF,
    parameter int TRIG_BITS    = TRIG_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);
    logic     q_valid, q_ready;
    in_item_t q_item;

    cma_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_item,
        .q_valid, .q_ready, .q_item
    );

    cma_back #(
        .COUNT_BITS(COUNT_BITS), .TRIG_BITS(TRIG_BITS), .CORDIC_STEPS(CORDIC_STEPS)
    ) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_item,
        .m_valid, .m_ready, .m_item
    );
endmodule

/* hw/rtl/cma_front.sv */
// Front end: two-entry queue toward the back end that zeroes the angle of
// clear items as they enter. Depends on cma_pkg.
module cma_front
    import cma_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    output logic     q_valid,
    input  logic     q_ready,
    output in_item_t q_item
);
    in_item_t   mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_item  = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg].cmd       <= s_item.cmd;
            mem_reg[wp_reg].angle_deg <= s_item.cmd ? 32'sd0 : s_item.angle_deg;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

/* hw/rtl/cma_back.sv */
// Back end: modulo reduction, shared iterative CORDIC (rotation then
// vectoring), accumulators and output register. Depends on cma_pkg.
module cma_back
    import cma_pkg::*;
#(
    parameter int COUNT_BITS   = COUNT_BITS_DEF,
    parameter int TRIG_BITS    = TRIG_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    output logic      q_ready,
    input  in_item_t  q_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);
    localparam int SW = COUNT_BITS + TRIG_BITS + 1;
    localparam int NSTEP = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int SH = VEC_FRAC - (TRIG_BITS - 1);
    localparam int NW = (SW > VW) ? SW + 1 : VW + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic signed [VW-1:0] TLIM = VW'((64'sd1 <<< (TRIG_BITS - 1)) - 1);
    localparam logic signed [NW-1:0] ONE_Q30 = NW'(64'sd1 <<< VEC_FRAC);
    localparam logic signed [NW-1:0] HALF_Q30 = NW'(64'sd1 <<< (VEC_FRAC - 1));

    localparam logic [3:0] ST_IDLE = 4'd0, ST_MOD = 4'd1, ST_ROTP = 4'd2,
        ST_ROT = 4'd3, ST_ACC = 4'd4, ST_NSH = 4'd5, ST_VPRE = 4'd6,
        ST_VEC = 4'd7, ST_FIN = 4'd8, ST_OUT = 4'd9;

    logic [3:0]              st_reg, st_next;
    logic [COUNT_BITS-1:0]   cnt_reg;
    logic signed [SW-1:0]    csum_reg, ssum_reg;
    logic signed [39:0]      rem_reg;
    logic [3:0]              mstep_reg;
    logic signed [NW-1:0]    x_reg, y_reg;
    logic signed [ZW-1:0]    z_reg;
    logic [4:0]              it_reg;
    logic                    neg_reg, full_reg, vec_reg;
    logic signed [NW-1:0]    m_reg;
    logic                    mfirst_reg;
    out_item_t               out_reg;
    logic                    out_v_reg;

    logic signed [NW-1:0] dx, dy, ax, ay, mx, mcur;
    logic                 dirp;
    logic signed [VW-1:0] cx, cy, rx, ry;
    logic signed [ZW-1:0] zq, zr, zrot;
    logic signed [39:0]   sub;

    function automatic logic signed [VW-1:0] to_trig(input logic signed [NW-1:0] v);
        logic signed [NW-1:0] r;
        begin
            r = (v + (NW'(1) <<< (SH - 1))) >>> SH;
            if (r > NW'(TLIM)) r = NW'(TLIM);
            if (r < -NW'(TLIM)) r = -NW'(TLIM);
            return VW'(r);
        end
    endfunction

    assign dx   = y_reg >>> it_reg;
    assign dy   = x_reg >>> it_reg;
    assign dirp = vec_reg ? (y_reg >= 0) : (z_reg >= 0);
    assign ax   = x_reg[NW-1] ? -x_reg : x_reg;
    assign ay   = y_reg[NW-1] ? -y_reg : y_reg;
    assign mx   = (ax > ay) ? ax : ay;
    // magnitude is shifted on its own, so a halving rounds down like the vector scaling
    assign mcur = mfirst_reg ? mx : m_reg;
    assign sub  = rem_reg - (40'sd23592960 <<< mstep_reg);
    assign cx   = to_trig(neg_reg ? -x_reg : x_reg);
    assign cy   = to_trig(neg_reg ? -y_reg : y_reg);
    assign rx   = cx;
    assign ry   = cy;
    assign zrot = ZW'(rem_reg) <<< 8;
    assign zq   = (z_reg + ZW'(128)) >>> 8;
    assign zr   = zq[ZW-1] ? zq + ZW'(FULL_TURN_Q16) :
                  (zq >= ZW'(FULL_TURN_Q16) ? zq - ZW'(FULL_TURN_Q16) : zq);

    assign q_ready = (st_reg == ST_IDLE) && !out_v_reg;
    assign m_valid = out_v_reg;
    assign m_item  = out_reg;

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (q_valid && q_ready) begin
                if (q_item.cmd == CMD_CLEAR) st_next = ST_OUT;
                else if (cnt_reg == COUNT_MAX) st_next = ST_NSH;
                else st_next = ST_MOD;
            end
            ST_MOD:  if (mstep_reg == 4'd0) st_next = ST_ROTP;
            ST_ROTP: st_next = ST_ROT;
            ST_ROT:  if (it_reg == 5'(NSTEP - 1)) st_next = ST_ACC;
            ST_ACC:  st_next = ST_NSH;
            ST_NSH:  if (x_reg == 0 && y_reg == 0) st_next = ST_FIN;
                     else if (mcur >= ONE_Q30 || mcur < HALF_Q30) st_next = ST_NSH;
                     else st_next = ST_VPRE;
            ST_VPRE: st_next = ST_VEC;
            ST_VEC:  if (it_reg == 5'(NSTEP - 1)) st_next = ST_FIN;
            ST_FIN:  st_next = ST_OUT;
            ST_OUT:  st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            cnt_reg   <= '0;
            csum_reg  <= '0;
            ssum_reg  <= '0;
            out_v_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (out_v_reg && m_ready) out_v_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE: if (q_valid && q_ready) begin
                    full_reg   <= (q_item.cmd != CMD_CLEAR) && (cnt_reg == COUNT_MAX);
                    rem_reg    <= 40'(q_item.angle_deg);
                    mstep_reg  <= 4'd12;
                    x_reg      <= NW'(csum_reg);
                    y_reg      <= NW'(ssum_reg);
                    z_reg      <= '0;
                    mfirst_reg <= 1'b1;
                    if (q_item.cmd == CMD_CLEAR) begin
                        cnt_reg  <= '0;
                        csum_reg <= '0;
                        ssum_reg <= '0;
                    end
                end
                ST_MOD: begin
                    if (mstep_reg == 4'd12 && rem_reg < 0)
                        rem_reg <= rem_reg + (40'sd23592960 <<< 7);
                    else if (!sub[39])
                        rem_reg <= sub;
                    if (!(mstep_reg == 4'd12 && rem_reg < 0) && mstep_reg != 4'd0)
                        mstep_reg <= mstep_reg - 4'd1;
                end
                ST_ROTP: begin
                    x_reg   <= NW'(GAIN_Q30);
                    y_reg   <= '0;
                    it_reg  <= '0;
                    vec_reg <= 1'b0;
                    if (zrot > DEG180 && (zrot - DEG360) < -DEG90) begin
                        z_reg   <= zrot - DEG180;
                        neg_reg <= 1'b1;
                    end else if (zrot > DEG180) begin
                        z_reg   <= zrot - DEG360;
                        neg_reg <= 1'b0;
                    end else if (zrot > DEG90) begin
                        z_reg   <= zrot - DEG180;
                        neg_reg <= 1'b1;
                    end else begin
                        z_reg   <= zrot;
                        neg_reg <= 1'b0;
                    end
                end
                ST_ROT, ST_VEC: begin
                    if (dirp) begin
                        x_reg <= vec_reg ? x_reg + dx : x_reg - dx;
                        y_reg <= vec_reg ? y_reg - dy : y_reg + dy;
                        z_reg <= vec_reg ? z_reg + atan_lut(it_reg) : z_reg - atan_lut(it_reg);
                    end else begin
                        x_reg <= vec_reg ? x_reg - dx : x_reg + dx;
                        y_reg <= vec_reg ? y_reg + dy : y_reg - dy;
                        z_reg <= vec_reg ? z_reg - atan_lut(it_reg) : z_reg + atan_lut(it_reg);
                    end
                    it_reg <= it_reg + 5'd1;
                end
                ST_ACC: begin
                    cnt_reg  <= cnt_reg + COUNT_BITS'(1);
                    csum_reg <= csum_reg + SW'(rx);
                    ssum_reg <= ssum_reg + SW'(ry);
                    x_reg    <= NW'(csum_reg + SW'(rx));
                    y_reg    <= NW'(ssum_reg + SW'(ry));
                    z_reg    <= '0;
                end
                ST_NSH: begin
                    if (!(x_reg == 0 && y_reg == 0)) begin
                        if (mcur >= ONE_Q30) begin
                            x_reg <= x_reg >>> 1;
                            y_reg <= y_reg >>> 1;
                            m_reg <= mcur >>> 1;
                        end else if (mcur < HALF_Q30) begin
                            x_reg <= x_reg <<< 1;
                            y_reg <= y_reg <<< 1;
                            m_reg <= mcur <<< 1;
                        end else begin
                            m_reg <= mcur;
                        end
                    end
                    mfirst_reg <= 1'b0;
                    z_reg      <= '0;
                    vec_reg    <= 1'b1;
                    it_reg     <= '0;
                end
                ST_VPRE: if (x_reg < 0) begin
                    x_reg <= -x_reg;
                    y_reg <= -y_reg;
                    z_reg <= DEG180;
                end
                ST_FIN: z_reg <= zr;
                ST_OUT: begin
                    out_v_reg            <= 1'b1;
                    out_reg.sample_count <= 20'(cnt_reg);
                    out_reg.mean_valid   <= (cnt_reg != 0);
                    out_reg.mean_angle   <= (cnt_reg != 0) ? 25'(z_reg) : 25'd0;
                    out_reg.count_full   <= full_reg;
                end
                default: ;
            endcase
        end
    end
endmodule
